>>> rtl/core/maximal_rectangle_binary_matrix_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef MAXIMAL_RECTANGLE_BINARY_MATRIX_MACROS_SVH
`define MAXIMAL_RECTANGLE_BINARY_MATRIX_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MRBM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MRBM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mrbm_pkg.sv
package mrbm_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLS + 1);
  localparam int HGT_W  = $clog2(MAX_ROWS + 1);
  localparam int AREA_W = 13;
  localparam int PROD_W = HGT_W + CNT_W;
  localparam int STK_W  = COL_W + HGT_W;
  localparam int CFG_W  = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Register word index taken from paddr[2].
  localparam logic REG_COLUMNS_IN_USE = 1'b0;

  typedef struct packed {
    logic cap;
    logic upd;
    logic rd;
    logic pop;
    logic push;
    logic fetch;
    logic emit;
  } mrbm_cmd_t;

  typedef struct packed {
    logic row_end;
    logic last;
    logic pop_cond;
    logic i_at_n;
    logic sp_gt1;
    logic out_free;
  } mrbm_sts_t;

endpackage

>>> rtl/core/maximal_rectangle_binary_matrix.sv
// Largest all-ones rectangle of a binary matrix that arrives one cell per
// transfer in row-major order, with last_cell set on the final cell. The
// block keeps a height of consecutive ones for every column and, when a row
// is complete, sweeps those heights with a monotonic stack to find the
// largest rectangle standing on that row. The transfer carrying last_cell
// yields one result transfer with max_area, after which the matrix state is
// cleared; a short final row is padded with clear cells. The row width comes
// from the columns_in_use register at byte address 0 (0 acts as 1, values
// above 64 act as 64); it should be written only while the block is idle.
// A cell that does not end a row reads the column height from its RAM and
// then writes the update. A cell that ends a row also runs the histogram
// sweep, paced by the single read port of the height RAM and of the stack
// RAM: each column pushed is read and then compared, a popped column needs
// the new top fetched from the stack RAM unless its pop empties the stack,
// and the end-of-row sentinel closes the sweep. A new cell is taken only
// once the last one is done. The last cell then moves the area into the
// output register once that register is free; the register holds it until
// the downstream side takes it while new cells keep flowing.
// Heights saturate at 64 rows, so max_area never exceeds 4096.
module maximal_rectangle_binary_matrix (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mrbm_pkg::ADDR_W-1:0]       paddr,
  input  logic [mrbm_pkg::DATA_W-1:0]       pwdata,
  output logic [mrbm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  // Cell input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cell_req,
  input  logic                              last_cell,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mrbm_pkg::AREA_W-1:0]       max_area
);

  logic [mrbm_pkg::CFG_W-1:0] columns_in_use;
  logic [mrbm_pkg::CNT_W-1:0] n_cols;
  logic                       reg_sel;
  mrbm_pkg::mrbm_cmd_t        cmd;
  mrbm_pkg::mrbm_sts_t        sts;

  // The port never stalls a transfer.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == mrbm_pkg::REG_COLUMNS_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= mrbm_pkg::CFG_W'(mrbm_pkg::MAX_COLS);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      columns_in_use <= pwdata[mrbm_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? mrbm_pkg::DATA_W'(columns_in_use) : '0;

  // Clamp the programmed width to the range the storage supports.
  always_comb begin
    if (columns_in_use == '0) begin
      n_cols = mrbm_pkg::CNT_W'(1);
    end else if (mrbm_pkg::CNT_W'(columns_in_use) > mrbm_pkg::CNT_W'(mrbm_pkg::MAX_COLS)) begin
      n_cols = mrbm_pkg::CNT_W'(mrbm_pkg::MAX_COLS);
    end else begin
      n_cols = mrbm_pkg::CNT_W'(columns_in_use);
    end
  end

  mrbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrbm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .n_cols    (n_cols),
    .cell_req  (cell_req),
    .last_cell (last_cell),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .max_area  (max_area)
  );

endmodule

>>> rtl/core/mrbm_ram.sv
module mrbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mrbm_ctrl.sv
module mrbm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrbm_pkg::mrbm_sts_t sts,
  output mrbm_pkg::mrbm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_RD,
    S_CMP,
    S_FETCH,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = sts.row_end ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.pop_cond) begin
          cmd.pop    = 1'b1;
          state_next = sts.sp_gt1 ? S_FETCH : S_CMP;
        end else if (!sts.i_at_n) begin
          cmd.push   = 1'b1;
          state_next = S_RD;
        end else begin
          state_next = sts.last ? S_DONE : S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_CMP;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/mrbm_dp.sv
module mrbm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mrbm_pkg::CNT_W-1:0]      n_cols,
  input  logic                            cell_req,
  input  logic                            last_cell,
  input  mrbm_pkg::mrbm_cmd_t             cmd,
  output mrbm_pkg::mrbm_sts_t             sts,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [mrbm_pkg::AREA_W-1:0]     max_area
);

  logic                            cell_q;
  logic                            last_q;
  logic [mrbm_pkg::COL_W-1:0]      col_q;
  logic [mrbm_pkg::COL_W-1:0]      pos;
  logic [mrbm_pkg::MAX_COLS-1:0]   vld;
  logic                            hv_q;
  logic [mrbm_pkg::CNT_W-1:0]      i_q;
  logic [mrbm_pkg::CNT_W-1:0]      sp;
  logic [mrbm_pkg::COL_W-1:0]      top_left;
  logic [mrbm_pkg::HGT_W-1:0]      top_h;
  logic [mrbm_pkg::COL_W-1:0]      left_cur;
  logic [mrbm_pkg::AREA_W-1:0]     best;

  logic [mrbm_pkg::CNT_W-1:0]      n_m1;
  logic [mrbm_pkg::COL_W-1:0]      col_calc;
  logic [mrbm_pkg::HGT_W-1:0]      h_rdata;
  logic [mrbm_pkg::HGT_W-1:0]      h_cur;
  logic [mrbm_pkg::HGT_W-1:0]      h_i;
  logic [mrbm_pkg::HGT_W-1:0]      h_new;
  logic                            row_end;
  logic                            i_at_n;
  logic [mrbm_pkg::COL_W-1:0]      h_raddr;
  logic [mrbm_pkg::CNT_W-1:0]      width;
  logic [mrbm_pkg::PROD_W-1:0]     prod;
  logic [mrbm_pkg::AREA_W-1:0]     area;
  logic [mrbm_pkg::CNT_W-1:0]      sp_m1;
  logic [mrbm_pkg::CNT_W-1:0]      sp_m2;
  logic [mrbm_pkg::STK_W-1:0]      s_rdata;

  assign n_m1     = n_cols - mrbm_pkg::CNT_W'(1);
  assign col_calc = ({1'b0, pos} < n_cols) ? pos : n_m1[mrbm_pkg::COL_W-1:0];
  assign h_raddr  = cmd.cap ? col_calc : i_q[mrbm_pkg::COL_W-1:0];
  assign h_cur    = hv_q ? h_rdata : '0;
  assign i_at_n   = (i_q == n_cols);
  assign h_i      = i_at_n ? '0 : h_cur;
  assign row_end  = (col_q == n_m1[mrbm_pkg::COL_W-1:0]) || last_q;

  always_comb begin
    if (!cell_q) begin
      h_new = '0;
    end else if (h_cur < mrbm_pkg::HGT_W'(mrbm_pkg::MAX_ROWS)) begin
      h_new = h_cur + mrbm_pkg::HGT_W'(1);
    end else begin
      h_new = h_cur;
    end
  end

  // Width of the popped bar runs from its left edge up to the current column.
  assign width = i_q - {1'b0, top_left};
  assign prod  = top_h * width;
  assign area  = (prod > mrbm_pkg::PROD_W'(mrbm_pkg::AREA_MAX)) ? mrbm_pkg::AREA_MAX
                                                               : prod[mrbm_pkg::AREA_W-1:0];
  assign sp_m1 = sp - mrbm_pkg::CNT_W'(1);
  assign sp_m2 = sp - mrbm_pkg::CNT_W'(2);

  assign sts.row_end  = row_end;
  assign sts.last     = last_q;
  assign sts.pop_cond = (sp != '0) && (i_at_n || (top_h >= h_i));
  assign sts.i_at_n   = i_at_n;
  assign sts.sp_gt1   = (sp > mrbm_pkg::CNT_W'(1));
  assign sts.out_free = !out_valid || out_ready;

  mrbm_ram #(
    .WIDTH (mrbm_pkg::HGT_W),
    .DEPTH (mrbm_pkg::MAX_COLS)
  ) u_height_ram (
    .clk   (clk),
    .we    (cmd.upd),
    .waddr (col_q),
    .wdata (h_new),
    .re    (cmd.cap || cmd.rd),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Entries below the top of stack; the top itself lives in top_left/top_h.
  mrbm_ram #(
    .WIDTH (mrbm_pkg::STK_W),
    .DEPTH (mrbm_pkg::MAX_COLS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push && (sp != '0)),
    .waddr (sp_m1[mrbm_pkg::COL_W-1:0]),
    .wdata ({top_left, top_h}),
    .re    (cmd.pop && sts.sp_gt1),
    .raddr (sp_m2[mrbm_pkg::COL_W-1:0]),
    .rdata (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cell_q <= cell_req;
      last_q <= last_cell;
      col_q  <= col_calc;
    end
    if (cmd.cap || cmd.rd) begin
      hv_q <= vld[h_raddr];
    end
    if (cmd.rd) begin
      left_cur <= i_q[mrbm_pkg::COL_W-1:0];
    end
    if (cmd.pop) begin
      left_cur <= top_left;
    end
    if (cmd.push) begin
      top_left <= left_cur;
      top_h    <= h_i;
    end
    if (cmd.fetch) begin
      {top_left, top_h} <= s_rdata;
    end
    if (cmd.emit) begin
      max_area <= best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      pos       <= '0;
      i_q       <= '0;
      sp        <= '0;
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.upd) begin
        vld[col_q] <= 1'b1;
        if (row_end) begin
          // Only the columns in use past the cell are padded; columns beyond
          // the current width keep their heights.
          for (int j = 0; j < mrbm_pkg::MAX_COLS; j++) begin
            if ((mrbm_pkg::COL_W'(j) > col_q) && (mrbm_pkg::CNT_W'(j) < n_cols)) begin
              vld[j] <= 1'b0;
            end
          end
          pos <= '0;
          i_q <= '0;
          sp  <= '0;
        end else begin
          pos <= col_q + mrbm_pkg::COL_W'(1);
        end
      end
      if (cmd.pop) begin
        sp <= sp_m1;
        if (area > best) begin
          best <= area;
        end
      end
      if (cmd.push) begin
        sp  <= sp + mrbm_pkg::CNT_W'(1);
        i_q <= i_q + mrbm_pkg::CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        vld       <= '0;
        best      <= '0;
        pos       <= '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/mrbm_checker.sv
`include "maximal_rectangle_binary_matrix_macros.svh"

module mrbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pready,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mrbm_pkg::AREA_W-1:0]   max_area
);

  `MRBM_ASSERT_NOW(a_pready_high, clk, rst, 1'b1, pready, "pready dropped")
  `MRBM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(max_area), "result changed while stalled")
  `MRBM_ASSERT_NOW(a_area_bound, clk, rst, out_valid, max_area <= mrbm_pkg::AREA_W'(mrbm_pkg::MAX_COLS * mrbm_pkg::MAX_ROWS), "area above matrix size")
  `MRBM_ASSERT_NOW(a_result_after_pass, clk, rst, $rose(out_valid), !$past(in_ready), "result appeared while cells were taken")

endmodule

bind maximal_rectangle_binary_matrix mrbm_checker u_mrbm_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .max_area  (max_area)
);

>>> tb/sv/tb_maximal_rectangle_binary_matrix.sv
module tb_maximal_rectangle_binary_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  import mrbm_pkg::*;

  // A row that ends runs the histogram sweep, and a last cell then loads the
  // output register. This is the wait that settle() gives the block to
  // finish before a register write.
  localparam int SWEEP_DRAIN = 300;
  // The watchdog fires after this many cycles without any transfer. It
  // covers the longest sweep, the longest receiver stall, a sender gap and
  // the drain pause several times over.
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_CELLS = 1750;
  localparam int TALL_ROWS = MAX_ROWS + 2;
  localparam int TALL_COLS = 2;

  localparam logic [ADDR_W-1:0] COLS_ADDR = {REG_COLUMNS_IN_USE, 2'b00};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              cell_req = 1'b0;
  logic              last_cell = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [AREA_W-1:0] max_area;

  maximal_rectangle_binary_matrix u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cell_req  (cell_req),
    .last_cell (last_cell),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .max_area  (max_area)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the column heights, the row position,
  // the running best area and the column count register.
  // ---------------------------------------------------------------------
  logic [HGT_W-1:0]  col_height [MAX_COLS];
  logic [COL_W-1:0]  col_pos;
  logic [AREA_W-1:0] best_so_far;
  logic [CFG_W-1:0]  cols_reg;

  // Areas of matrices whose final cell has been accepted, oldest first.
  logic [AREA_W-1:0] area_q [$];

  int unsigned err_count = 0;
  int unsigned cells_taken = 0;
  int unsigned areas_checked = 0;
  int unsigned largest_seen = 0;
  int unsigned quiet_cycles = 0;

  // Knobs for the traffic shaping; the random test flips them per matrix.
  bit tx_gaps = 1'b1;
  bit rx_stalls = 1'b1;
  int burst_left = 0;

  function automatic void clear_matrix();
    for (int j = 0; j < MAX_COLS; j++) col_height[j] = '0;
    col_pos = '0;
    best_so_far = '0;
  endfunction

  // The register value as the row logic sees it: zero acts as one column,
  // anything past the array width is clamped to the array width.
  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  // Largest rectangle under the current height profile, using a stack of
  // column indexes whose heights rise from bottom to top. A bar is popped
  // when a bar no taller arrives; its width runs from the entry below it
  // on the stack to the current column. The sentinel at column n empties
  // the stack.
  function automatic void sweep_heights(int n);
    int stk [MAX_COLS+1];
    int sp;
    int h;
    int top;
    int width;
    int area;
    sp = 0;
    for (int i = 0; i <= n; i++) begin
      h = (i < n) ? int'(col_height[i]) : 0;
      while (sp > 0 && (i == n || int'(col_height[stk[sp-1]]) >= h)) begin
        top = stk[sp-1];
        sp--;
        width = (sp == 0) ? i : i - stk[sp-1] - 1;
        area = int'(col_height[top]) * width;
        if (area > int'(AREA_MAX)) area = int'(AREA_MAX);
        if (area > int'(best_so_far)) best_so_far = area[AREA_W-1:0];
      end
      if (i < n) begin
        stk[sp] = i;
        sp++;
      end
    end
  endfunction

  // Advance the predictor by one accepted cell.
  function automatic void take_cell(logic cell_val, logic last);
    int n;
    int col;
    n = active_cols();
    // A position left past the row end by a lowered column count lands on
    // the last column in use and closes the row.
    col = (int'(col_pos) < n) ? int'(col_pos) : n - 1;
    if (cell_val) begin
      if (col_height[col] < MAX_ROWS) col_height[col]++;
    end else begin
      col_height[col] = '0;
    end
    if (col == n - 1 || last) begin
      // A short final row is padded with clear cells.
      for (int j = col + 1; j < n; j++) col_height[j] = '0;
      sweep_heights(n);
      col_pos = '0;
    end else begin
      col_pos = COL_W'(col + 1);
    end
    if (last) begin
      area_q.push_back(best_so_far);
      clear_matrix();
    end
  endfunction

  // Every cell transfer feeds the predictor. Values are read before the
  // driver's updates of this edge land, so the payload is the one that
  // was actually taken.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      take_cell(cell_req, last_cell);
      cells_taken++;
    end
  end

  // Every result transfer is checked against the oldest pending area.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (area_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got max_area %0d",
                 $time, max_area);
        err_count++;
      end else begin
        if (max_area !== area_q[0]) begin
          $display("%0t: max_area mismatch, expected %0d, got %0d",
                   $time, area_q[0], max_area);
          err_count++;
        end
        if (area_q[0] > largest_seen) largest_seen = area_q[0];
        void'(area_q.pop_front());
        areas_checked++;
      end
    end
  end

  // The receiver stalls on a 16-bit mask indexed by rx_tick[3:0] and redrawn
  // when rx_tick[5:0] is zero. Now and then an all-zero mask gives a long stall.
  logic [7:0]  rx_tick = '0;
  logic [15:0] rx_mask = 16'hffff;

  always @(posedge clk) begin
    if (rx_tick[5:0] == 6'd0) begin
      rx_mask = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
    end
    out_ready <= !rx_stalls || rx_mask[rx_tick[3:0]];
    rx_tick = rx_tick + 8'd1;
  end

  // Any transfer on any port counts as progress. A correct block never
  // stays silent this long, so a hang ends the run here.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Shared stimulus tasks. All of them are entered and left at a rising
  // edge, and every drive is a nonblocking assignment at that edge.
  // ---------------------------------------------------------------------

  // Present one cell and hold it until the block takes it. The sender
  // works in bursts; between bursts valid drops for a few cycles. Valid is
  // left high after the transfer so that back-to-back cells need no second
  // update in the same step.
  task automatic send_cell(input logic cell_val, input logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_gaps) gap = $urandom_range(0, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cell_req  <= cell_val;
    last_cell <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending, wait for every pending area and then give the block time
  // to finish a sweep whose row produced no result, so that it is idle.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (area_q.size() != 0) @(posedge clk);
    repeat (SWEEP_DRAIN) @(posedge clk);
  endtask

  // Write columns_in_use, then read it back. The read starts straight from
  // the write's access phase, keeping psel high.
  task automatic write_columns(input int unsigned value);
    logic [CFG_W-1:0] stored;
    stored = value[CFG_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COLS_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cols_reg = stored;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] !== stored) begin
      $display("%0t: columns_in_use readback mismatch, expected %0d, got %0d",
               $time, stored, prdata[CFG_W-1:0]);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Out of reset the row is 64 wide. A matrix that ends after five set
  // cells has its short final row padded with clear cells, so the answer
  // is the five-cell strip.
  task automatic test_reset_width_short_row();
    for (int k = 0; k < 5; k++) send_cell(1'b1, k == 4);
    settle();
  endtask

  // One-column rows: the answer is the longest vertical run of set cells.
  // A single-cell matrix in both values closes the test.
  task automatic test_single_column();
    write_columns(1);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b0, 1'b1);
    send_cell(1'b1, 1'b1);
    settle();
  endtask

  // Zero acts as one column; values past the array width act as 64.
  task automatic test_column_clamp();
    write_columns(0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
    write_columns(127);
    for (int k = 0; k < 3; k++) send_cell(1'b1, k == 2);
    settle();
    write_columns(MAX_COLS + 1);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    settle();
  endtask

  // Narrow the row while the write position is past the new width. The
  // next cell lands on the last column in use and ends the row; the
  // matrix built so far is kept.
  task automatic test_shrink_mid_row();
    write_columns(8);
    for (int k = 0; k < 5; k++) send_cell(1'b1, 1'b0);
    settle();
    write_columns(3);
    send_cell(1'b1, 1'b0);
    for (int k = 0; k < 3; k++) send_cell(1'b1, k == 2);
    settle();
  endtask

  // Tall all-ones matrices push every height past its 64-row ceiling: a
  // single column of 70 rows and a two-column block of 66 rows.
  task automatic test_height_saturation();
    write_columns(1);
    for (int k = 0; k < MAX_ROWS + 6; k++) send_cell(1'b1, k == MAX_ROWS + 5);
    settle();
    write_columns(TALL_COLS);
    tx_gaps = 1'b0;
    for (int k = 0; k < TALL_ROWS * TALL_COLS; k++) begin
      send_cell(1'b1, k == TALL_ROWS * TALL_COLS - 1);
    end
    tx_gaps = 1'b1;
    settle();
  endtask

  // Random matrices. Most are narrow and well formed with a bias toward set
  // cells, so that real rectangles form; some are wide, some sparse, and
  // some end early in the middle of a row. The width changes between
  // matrices, now and then to zero or past the array width.
  task automatic test_random_matrices();
    int sent;
    int n;
    int rows;
    int total;
    int density;
    int pick;
    int unsigned width_val;
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          width_val = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
        end else if (pick < 3) begin
          width_val = $urandom_range(9, MAX_COLS);
        end else begin
          width_val = $urandom_range(1, 8);
        end
        write_columns(width_val);
      end
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      n = active_cols();
      rows = (n > 16) ? $urandom_range(1, 4) : $urandom_range(1, 10);
      density = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 100)
                                             : $urandom_range(60, 100);
      total = rows * n;
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      for (int k = 0; k < total; k++) begin
        send_cell($urandom_range(0, 99) < density, k == total - 1);
      end
      sent += total;
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    settle();
  endtask

  initial begin
    for (int j = 0; j < MAX_COLS; j++) col_height[j] = '0;
    cols_reg = CFG_W'(MAX_COLS);
    clear_matrix();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_width_short_row();
    test_single_column();
    test_column_clamp();
    test_shrink_mid_row();
    test_height_saturation();
    test_random_matrices();

    if (area_q.size() != 0) begin
      $display("%0t: %0d areas never arrived", $time, area_q.size());
      err_count++;
    end
    $display("Streamed %0d cells and checked %0d rectangle areas.",
             cells_taken, areas_checked);
    $display("Widths from 0 to 127 were used; the largest area was %0d.",
             largest_seen);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/mrbm_pkg.sv
rtl/core/mrbm_ram.sv
rtl/core/mrbm_ctrl.sv
rtl/core/mrbm_dp.sv
rtl/core/maximal_rectangle_binary_matrix.sv
rtl/core/mrbm_checker.sv
tb/sv/tb_maximal_rectangle_binary_matrix.sv
